FILE: rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Types and codes shared by the priority task sorter cells, control and top.
// ----------------------------------------------------------------------------
package pts_pkg;

   // Operation codes of a request beat
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_SCHED = 1'b1;

   // One task record as held in a cell
   typedef struct packed {
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [7:0]  id;
   } rec_type;

   // What every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE
   } cell_mode_type;

   // Command broadcast from control to the whole chain
   typedef struct packed {
      cell_mode_type mode;
      rec_type       new_rec;
   } cell_ctrl_type;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_SCHED
   } state_type;

endpackage

FILE: rtl/core/pts_cell.sv
// ----------------------------------------------------------------------------
// pts_cell
// One slot of the sorted chain: holds a record, inserts or shifts on command.
// ----------------------------------------------------------------------------
module pts_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  pts_pkg::cell_ctrl_type ctrl,
   input  pts_pkg::rec_type       prev_rec,
   input  logic                   prev_valid,
   input  logic                   prev_ge,
   input  pts_pkg::rec_type       next_rec,
   input  logic                   next_valid,
   output pts_pkg::rec_type       rec,
   output logic                   valid,
   output logic                   ge
);
   import pts_pkg::*;

   rec_type rec_ff, rec_in;
   logic    valid_ff, valid_in;

   // Flag a record that stays ahead of the incoming one (ties keep arrival order)
   assign ge    = valid_ff && (rec_ff.prio >= ctrl.new_rec.prio);
   assign rec   = rec_ff;
   assign valid = valid_ff;

   // Pick the next content of the slot
   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (ge) begin
               rec_in   = rec_ff;
               valid_in = valid_ff;
            end else if (prev_ge) begin
               rec_in   = ctrl.new_rec;
               valid_in = 1'b1;
            end else begin
               rec_in   = prev_rec;
               valid_in = prev_valid;
            end
         end
         CELL_ROTATE: begin
            rec_in   = next_rec;
            valid_in = next_valid;
         end
         default: begin
            rec_in   = rec_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   // Hold the valid flag under reset, the payload free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

FILE: rtl/core/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: takes request beats, counts records, drives the chain and the
// result register.
// ----------------------------------------------------------------------------
module pts_ctrl #(
   parameter int MAX_TASKS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_operation,
   input  pts_pkg::rec_type       req_rec,
   input  pts_pkg::rec_type       head_rec,
   output logic                   busy,
   output pts_pkg::cell_ctrl_type cell_ctrl,
   output logic                   rsp_valid,
   output pts_pkg::rec_type       rsp_rec,
   output logic                   rsp_last,
   output logic                   rsp_rejected
);
   import pts_pkg::*;

   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int SW = $clog2(MAX_TASKS);

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] step_ff, step_in;
   logic          valid_ff, valid_in;
   rec_type       rec_ff, rec_in;
   logic          last_ff, last_in;
   logic          rej_ff, rej_in;

   logic          accept;
   logic          full;
   logic          step_end;
   logic          emit;
   cell_mode_type mode;

   assign accept   = start && !busy;
   assign full     = (count_ff == CW'(MAX_TASKS));
   assign step_end = (step_ff == SW'(MAX_TASKS - 1));
   assign emit     = (CW'(step_ff) < count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_SCHED)) begin
               state_in = ST_SCHED;
            end
         end
         ST_SCHED: begin
            if (step_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy = 1'b0;
      mode = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_ADD) && !full) begin
               mode = CELL_INSERT;
            end
         end
         ST_SCHED: begin
            busy = 1'b1;
            mode = CELL_ROTATE;
         end
         default: begin
            busy = 1'b0;
            mode = CELL_HOLD;
         end
      endcase
   end

   assign cell_ctrl.mode    = mode;
   assign cell_ctrl.new_rec = req_rec;

   // Advance record count and rotation step
   always_comb begin
      count_in = count_ff;
      if (mode == CELL_INSERT) begin
         count_in = count_ff + CW'(1);
      end
      step_in = '0;
      if (state_ff == ST_SCHED) begin
         step_in = step_ff + SW'(1);
      end
   end

   // Load the result register: a dropped add or the head of the chain
   always_comb begin
      valid_in = 1'b0;
      rec_in   = head_rec;
      last_in  = 1'b0;
      rej_in   = 1'b0;
      if (state_ff == ST_SCHED) begin
         valid_in = emit;
         last_in  = ((CW'(step_ff) + CW'(1)) == count_ff);
      end else if (accept && (req_operation == OP_ADD) && full) begin
         valid_in = 1'b1;
         rec_in   = req_rec;
         rej_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
      rej_ff  <= rej_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_rec      = rec_ff;
   assign rsp_last     = last_ff;
   assign rsp_rejected = rej_ff;

endmodule

FILE: rtl/core/priority_task_sorter_core.sv
// ----------------------------------------------------------------------------
// priority_task_sorter_core
// Stable priority queue built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage: drive req_* with start high; a beat is taken at an edge where busy
// is low. An add beat (req_operation = 0) places its record in the chain in
// the cycle it is taken, behind every record of greater or equal priority,
// so add beats may follow each other every cycle. An add into a full chain
// is dropped and answered in the next cycle by a single rsp beat with
// rsp_rejected set and the record echoed.
// A schedule beat (req_operation = 1) raises busy while the chain rotates
// once toward cell 0; each record in turn gives one rsp beat, in the cycle
// after the head cell is read, highest priority first, rsp_last on the
// final one. The full rotation restores the chain. An empty chain gives no
// rsp beat.
// rsp_valid marks each beat for exactly one cycle; the receiver cannot stall.
// Reset (synchronous) empties the chain and returns control to idle.
// ----------------------------------------------------------------------------
module priority_task_sorter_core #(
   parameter int MAX_TASKS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_burst,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_task_id,
   output logic [7:0]  rsp_out_priority,
   output logic [15:0] rsp_out_burst,
   output logic        rsp_last,
   output logic        rsp_rejected
);
   import pts_pkg::*;

   rec_type       req_rec;
   rec_type       rsp_rec;
   cell_ctrl_type cell_ctrl;

   rec_type       recs   [MAX_TASKS];
   logic          valids [MAX_TASKS];
   logic          ges    [MAX_TASKS];

   assign req_rec.id    = req_task_id;
   assign req_rec.prio  = req_priority_req;
   assign req_rec.burst = req_burst;

   pts_ctrl #(
      .MAX_TASKS (MAX_TASKS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_rec       (req_rec),
      .head_rec      (recs[0]),
      .busy          (busy),
      .cell_ctrl     (cell_ctrl),
      .rsp_valid     (rsp_valid),
      .rsp_rec       (rsp_rec),
      .rsp_last      (rsp_last),
      .rsp_rejected  (rsp_rejected)
   );

   // Build the chain: insert shifts toward the tail, rotate shifts toward the head and wraps the head to the tail
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == MAX_TASKS - 1) ? 0 : i + 1;

      logic prev_ge;
      assign prev_ge = (i == 0) ? 1'b1 : ges[PREV];

      pts_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .prev_rec   (recs[PREV]),
         .prev_valid (valids[PREV]),
         .prev_ge    (prev_ge),
         .next_rec   (recs[NEXT]),
         .next_valid (valids[NEXT]),
         .rec        (recs[i]),
         .valid      (valids[i]),
         .ge         (ges[i])
      );
   end

   assign rsp_out_task_id  = rsp_rec.id;
   assign rsp_out_priority = rsp_rec.prio;
   assign rsp_out_burst    = rsp_rec.burst;

endmodule

FILE: sim/priority_task_sorter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_sorter_core_test
// Self-checking bench for the stable priority task sorter. Add and schedule
// beats go in through the start/busy handshake. A scoreboard keeps its own
// ordered copy of the task store and predicts every rsp beat: the ordered
// record list on a schedule and the echo of a dropped record on a full add.
// Each rsp beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
import pts_pkg::*;

typedef struct packed {
   rec_type rec;
   logic    last;
   logic    rejected;
} task_beat_type;

class task_order_board;
   int unsigned   slots;
   rec_type       ordered_q[$];
   task_beat_type due_q[$];
   int unsigned   mismatch_count;

   function new(int unsigned slot_count);
      slots          = slot_count;
      mismatch_count = 0;
   endfunction

   // Work out the rsp beats that one accepted request beat causes
   function void note_request(logic op, rec_type rec);
      int unsigned   pos;
      task_beat_type beat;
      if (op == OP_SCHED) begin
         // emit the whole store in order, keep it afterward
         foreach (ordered_q[i]) begin
            beat.rec      = ordered_q[i];
            beat.last     = (i == ordered_q.size() - 1);
            beat.rejected = 1'b0;
            due_q.push_back(beat);
         end
      end else if (ordered_q.size() >= slots) begin
         // full store: drop the record and echo it back
         beat.rec      = rec;
         beat.last     = 1'b0;
         beat.rejected = 1'b1;
         due_q.push_back(beat);
      end else begin
         // insert behind every record of greater or equal priority
         pos = ordered_q.size();
         while (pos > 0 && ordered_q[pos - 1].prio < rec.prio)
            pos--;
         ordered_q.insert(pos, rec);
      end
   endfunction

   // Compare one rsp beat with the oldest prediction
   task check_response(task_beat_type got);
      task_beat_type want;
      if (due_q.size() == 0) begin
         report($sformatf("unexpected rsp beat id %0d prio %0d burst %0d",
                          got.rec.id, got.rec.prio, got.rec.burst));
         return;
      end
      want = due_q.pop_front();
      if (got.rec.id !== want.rec.id)
         report($sformatf("task id %0d, want %0d", got.rec.id, want.rec.id));
      if (got.rec.prio !== want.rec.prio)
         report($sformatf("priority %0d, want %0d", got.rec.prio, want.rec.prio));
      if (got.rec.burst !== want.rec.burst)
         report($sformatf("burst %0d, want %0d", got.rec.burst, want.rec.burst));
      if (got.last !== want.last)
         report($sformatf("last %b, want %b", got.last, want.last));
      if (got.rejected !== want.rejected)
         report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
   endtask

   task report(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask
endclass

module priority_task_sorter_core_test;

   localparam int TASK_SLOTS   = 32;
   localparam int RANDOM_BEATS = 98;
   localparam int CYCLE_LIMIT  = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation    = OP_ADD;
   logic [7:0]  req_task_id      = '0;
   logic [7:0]  req_priority_req = '0;
   logic [15:0] req_burst        = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_out_task_id;
   logic [7:0]  rsp_out_priority;
   logic [15:0] rsp_out_burst;
   logic        rsp_last;
   logic        rsp_rejected;

   task_order_board board;
   int unsigned     cycle_count = 0;

   priority_task_sorter_core #(
      .MAX_TASKS(TASK_SLOTS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_task_id     (req_task_id),
      .req_priority_req(req_priority_req),
      .req_burst       (req_burst),
      .rsp_valid       (rsp_valid),
      .rsp_out_task_id (rsp_out_task_id),
      .rsp_out_priority(rsp_out_priority),
      .rsp_out_burst   (rsp_out_burst),
      .rsp_last        (rsp_last),
      .rsp_rejected    (rsp_rejected)
   );

   always #4 clock = ~clock;

   // Check rsp beats first, then note the request beat taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            board.check_response({rsp_out_burst, rsp_out_priority, rsp_out_task_id,
                                  rsp_last, rsp_rejected});
         if (start && !busy)
            board.note_request(req_operation, {req_burst, req_priority_req, req_task_id});
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_task_sorter_core test failed");
         $finish;
      end
   end

   // Present one beat and hold it until the block takes it; start stays high
   task automatic send_beat(logic op, logic [7:0] id, logic [7:0] prio, logic [15:0] burst);
      start            <= 1'b1;
      req_operation    <= op;
      req_task_id      <= id;
      req_priority_req <= prio;
      req_burst        <= burst;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles
   task automatic idle_gap(int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Random beat: mostly adds, priorities often drawn from a few values for ties
   task automatic random_beat();
      logic       op;
      logic [7:0] prio;
      op = ($urandom_range(0, 5) == 0) ? OP_SCHED : OP_ADD;
      if ($urandom_range(0, 1) == 1)
         prio = 8'($urandom_range(0, 255));
      else
         prio = 8'($urandom_range(0, 3) * 85);
      send_beat(op, 8'($urandom_range(0, 255)), prio, 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      int unsigned idle_pct;
      int unsigned gap;
      board = new(TASK_SLOTS);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty schedule, field extremes, ties at head, middle and tail
      send_beat(OP_SCHED, 8'h00, 8'h00, 16'h0000);
      send_beat(OP_ADD,   8'h00, 8'h00, 16'h0000);
      send_beat(OP_ADD,   8'hFF, 8'hFF, 16'hFFFF);
      send_beat(OP_ADD,   8'hAA, 8'h80, 16'h5555);
      send_beat(OP_ADD,   8'h55, 8'h80, 16'hAAAA);
      send_beat(OP_ADD,   8'h01, 8'h00, 16'hFFFF);
      send_beat(OP_ADD,   8'hFE, 8'hFF, 16'h0001);
      send_beat(OP_SCHED, 8'hFF, 8'hFF, 16'hFFFF);
      send_beat(OP_SCHED, 8'h00, 8'h00, 16'h0000);
      send_beat(OP_ADD,   8'h7F, 8'h80, 16'h8000);
      send_beat(OP_ADD,   8'h80, 8'h7F, 16'h7FFF);
      send_beat(OP_SCHED, 8'h5A, 8'hA5, 16'h1234);

      // Random: four idling phases, the store fills and adds start to bounce
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         case (n * 4 / RANDOM_BEATS)
            1:       idle_pct = 54;
            3:       idle_pct = 17;
            default: idle_pct = 0;
         endcase
         random_beat();
         // idle each following cycle with the phase's probability
         gap = 0;
         while ($urandom_range(0, 99) < idle_pct)
            gap++;
         idle_gap(gap);
      end
      start <= 1'b0;

      // Drain, then let a full rotation pass to catch stray beats
      while (board.due_q.size() != 0)
         @(posedge clock);
      repeat (TASK_SLOTS + 4) @(posedge clock);

      if (board.mismatch_count == 0)
         $display("priority_task_sorter_core test passed");
      else
         $display("priority_task_sorter_core test failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/pts_pkg.sv
rtl/core/pts_cell.sv
rtl/core/pts_ctrl.sv
rtl/core/priority_task_sorter_core.sv
sim/priority_task_sorter_core_test.sv
